### src/kts_pkg.sv
// shared types and constants for the keyframe track sampler
package kts_pkg;

   // field widths fixed by the interface
   localparam int KEY_INDEX_W = 6;
   localparam int TIME_W      = 32;
   localparam int VALUE_W     = 32;
   localparam int KEY_COUNT_W = 7;
   localparam int CSR_DATA_W  = 7;
   localparam int CSR_INDEX_W = 1;

   // request tdata layout, lowest bits first
   localparam int REQ_DATA_W  = 136;
   localparam int RSP_DATA_W  = 96;

   // request kinds carried on tuser
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

   // response status carried on tuser
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   // interpolation modes
   localparam logic MODE_STEP   = 1'b0;
   localparam logic MODE_LINEAR = 1'b1;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERP_MODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_COUNT   = 1'b1;

   // sequencer states
   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_SCAN = 8'b0000_0010,
      S_LD_A = 8'b0000_0100,
      S_LD_B = 8'b0000_1000,
      S_DIV  = 8'b0001_0000,
      S_MUL  = 8'b0010_0000,
      S_ACC  = 8'b0100_0000,
      S_DONE = 8'b1000_0000
   } state_type;

endpackage

### src/keyframe_track_sampler.sv
// keyframe track sampler: keyframe table, linear search, serial divider and shared multiplier
//
// Holds up to MAX_KEYS keyframes (time plus x, y, z, all Q16.16) in on-chip memory. A write
// beat stores one keyframe and the block stays ready for the next beat. A sample beat scans
// the table one entry per cycle from slot 0 until it meets a key time above the query or
// reaches the last key in use, then reads the keyframe found. Step mode, the last key, or a
// query before the first key return that keyframe directly. Linear mode also reads the next
// key, runs a restoring divider one quotient bit per cycle to get k, and then uses one
// multiplier for the three components in turn, a multiply step and then an accumulate step
// for each. An empty table answers with status set and zero data. The result sits in an
// output register, so a new beat may be taken while it waits.
module keyframe_track_sampler #(
   parameter int MAX_KEYS  = 64,
   parameter int FRAC_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: key_index[5:0], time_req[37:6], value_x[69:38], value_y[101:70],
   //        value_z[133:102], zero fill[135:134]
   input  logic [kts_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: req_type
   input  logic                              req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: out_x[31:0], out_y[63:32], out_z[95:64]
   output logic [kts_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // tuser: status
   output logic                              rsp_tuser,
   // configuration write port
   input  logic                              csr_we,
   input  logic [kts_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [kts_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW    = $clog2(MAX_KEYS);
   localparam int CW    = $clog2(MAX_KEYS + 1);
   localparam int NW    = (CW > kts_pkg::KEY_COUNT_W) ? CW : kts_pkg::KEY_COUNT_W;
   localparam int IXW   = AW + kts_pkg::KEY_INDEX_W;
   localparam int DCW   = $clog2(FRAC_BITS + 1);
   localparam int DW    = kts_pkg::VALUE_W + 1;
   localparam int PW    = FRAC_BITS + 1 + DW;
   localparam int TW    = kts_pkg::TIME_W;
   localparam int VW    = kts_pkg::VALUE_W;

   // request field unpacking
   logic [kts_pkg::KEY_INDEX_W-1:0] req_key_index;
   logic [TW-1:0]                   req_time;
   logic [VW-1:0]                   req_value [3];

   assign req_key_index = req_tdata[5:0];
   assign req_time      = req_tdata[37:6];
   assign req_value[0]  = req_tdata[69:38];
   assign req_value[1]  = req_tdata[101:70];
   assign req_value[2]  = req_tdata[133:102];

   // state
   kts_pkg::state_type state_ff, state_in;

   logic                          interp_mode_ff;
   logic [kts_pkg::KEY_COUNT_W-1:0] key_count_ff;

   logic [CW-1:0]   n_ff;
   logic [CW-1:0]   scan_idx_ff;
   logic [AW-1:0]   found_ff;
   logic            before_first_ff;
   logic [TW-1:0]   t_ff;
   logic [TW-1:0]   t0_ff;
   logic [TW-1:0]   rem_ff;
   logic [TW-1:0]   den_ff;
   logic [FRAC_BITS-1:0] k_ff;
   logic [DCW-1:0]  div_cnt_ff;
   logic [1:0]      comp_ff;
   logic [VW-1:0]   a_ff    [3];
   logic signed [DW-1:0] diff_ff [3];
   logic signed [PW-1:0] prod_ff;
   logic [VW-1:0]   res_ff  [3];
   logic            res_status_ff;

   logic            rsp_valid_ff;
   logic [VW-1:0]   rsp_out_ff [3];
   logic            rsp_status_ff;

   // keyframe memory and its registered read port
   logic [TW-1:0]   key_time_mem [MAX_KEYS];
   logic [VW-1:0]   key_x_mem    [MAX_KEYS];
   logic [VW-1:0]   key_y_mem    [MAX_KEYS];
   logic [VW-1:0]   key_z_mem    [MAX_KEYS];
   logic [TW-1:0]   rd_time_ff;
   logic [VW-1:0]   rd_value_ff [3];

   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [IXW-1:0]  idx_ext;

   // handshake
   logic req_beat;
   logic rsp_beat;
   logic rsp_load;

   assign req_tready = (state_ff == kts_pkg::S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_beat   = rsp_valid_ff && rsp_tready;
   assign rsp_load   = (state_ff == kts_pkg::S_DONE) && (!rsp_valid_ff || rsp_tready);

   // clamped key count
   logic [NW-1:0] n_ext;
   always_comb begin
      n_ext = NW'(key_count_ff);
      if (n_ext > NW'(MAX_KEYS)) begin
         n_ext = NW'(MAX_KEYS);
      end
   end

   // scan compare and stop decision
   logic [CW-1:0] scan_nxt;
   logic          cur_lt;
   logic          scan_last;
   logic          hold_sel;

   assign scan_nxt  = scan_idx_ff + CW'(1);
   assign cur_lt    = t_ff < rd_time_ff;
   assign scan_last = (scan_idx_ff == n_ff - CW'(1));
   assign hold_sel  = (interp_mode_ff == kts_pkg::MODE_STEP) ||
                      (CW'(found_ff) == n_ff - CW'(1)) || before_first_ff;

   // write address, ignoring slots beyond the table
   assign idx_ext = IXW'(req_key_index);
   assign wr_addr = idx_ext[AW-1:0];
   assign wr_en   = req_beat && (req_tuser == kts_pkg::REQ_WRITE) &&
                    (idx_ext < IXW'(MAX_KEYS));

   // read address selection
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      unique case (state_ff)
         kts_pkg::S_IDLE: begin
            rd_en = req_beat && (req_tuser == kts_pkg::REQ_SAMPLE);
         end
         kts_pkg::S_SCAN: begin
            rd_en = 1'b1;
            if (cur_lt) begin
               rd_addr = found_ff;
            end else if (scan_last) begin
               rd_addr = scan_idx_ff[AW-1:0];
            end else begin
               rd_addr = scan_nxt[AW-1:0];
            end
         end
         kts_pkg::S_LD_A: begin
            rd_en   = !hold_sel;
            rd_addr = found_ff + AW'(1);
         end
         default: begin
            rd_en   = 1'b0;
            rd_addr = '0;
         end
      endcase
   end

   // keyframe memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_time_mem[wr_addr] <= req_time;
         key_x_mem[wr_addr]    <= req_value[0];
         key_y_mem[wr_addr]    <= req_value[1];
         key_z_mem[wr_addr]    <= req_value[2];
      end
      if (rd_en) begin
         rd_time_ff     <= key_time_mem[rd_addr];
         rd_value_ff[0] <= key_x_mem[rd_addr];
         rd_value_ff[1] <= key_y_mem[rd_addr];
         rd_value_ff[2] <= key_z_mem[rd_addr];
      end
   end

   // divider step
   logic [TW:0]   rem_sh;
   logic          div_ge;
   logic [TW:0]   rem_sub;

   assign rem_sh  = {rem_ff, 1'b0};
   assign div_ge  = rem_sh >= {1'b0, den_ff};
   assign rem_sub = rem_sh - {1'b0, den_ff};

   // multiply and accumulate for one component
   logic signed [PW-1:0] prod_in;
   logic signed [PW-1:0] a_ext;
   logic signed [PW-1:0] sum_full;

   assign prod_in  = $signed({1'b0, k_ff}) * diff_ff[comp_ff];
   assign a_ext    = PW'($signed(a_ff[comp_ff]));
   assign sum_full = a_ext + (prod_ff >>> FRAC_BITS);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kts_pkg::S_IDLE: begin
            if (req_beat && (req_tuser == kts_pkg::REQ_SAMPLE)) begin
               state_in = (n_ext == '0) ? kts_pkg::S_DONE : kts_pkg::S_SCAN;
            end
         end
         kts_pkg::S_SCAN: begin
            if (cur_lt || scan_last) begin
               state_in = kts_pkg::S_LD_A;
            end
         end
         kts_pkg::S_LD_A: begin
            state_in = hold_sel ? kts_pkg::S_DONE : kts_pkg::S_LD_B;
         end
         kts_pkg::S_LD_B: begin
            state_in = kts_pkg::S_DIV;
         end
         kts_pkg::S_DIV: begin
            if (div_cnt_ff == '0) begin
               state_in = kts_pkg::S_MUL;
            end
         end
         kts_pkg::S_MUL: begin
            state_in = kts_pkg::S_ACC;
         end
         kts_pkg::S_ACC: begin
            state_in = (comp_ff == 2'd2) ? kts_pkg::S_DONE : kts_pkg::S_MUL;
         end
         kts_pkg::S_DONE: begin
            if (rsp_load) begin
               state_in = kts_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = kts_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= kts_pkg::S_IDLE;
         interp_mode_ff <= kts_pkg::MODE_LINEAR;
         key_count_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               kts_pkg::CSR_INTERP_MODE: interp_mode_ff <= csr_wdata[0];
               kts_pkg::CSR_KEY_COUNT:   key_count_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_beat) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      unique case (state_ff)
         kts_pkg::S_IDLE: begin
            if (req_beat && (req_tuser == kts_pkg::REQ_SAMPLE)) begin
               t_ff            <= req_time;
               n_ff            <= CW'(n_ext);
               scan_idx_ff     <= '0;
               found_ff        <= '0;
               before_first_ff <= 1'b0;
               res_ff[0]       <= '0;
               res_ff[1]       <= '0;
               res_ff[2]       <= '0;
               res_status_ff   <= (n_ext == '0) ? kts_pkg::STATUS_EMPTY : kts_pkg::STATUS_OK;
            end
         end
         kts_pkg::S_SCAN: begin
            if (scan_idx_ff == '0) begin
               before_first_ff <= cur_lt;
            end
            if (!cur_lt) begin
               found_ff <= scan_idx_ff[AW-1:0];
               if (!scan_last) begin
                  scan_idx_ff <= scan_nxt;
               end
            end
         end
         kts_pkg::S_LD_A: begin
            // hold path takes the keyframe as it is
            if (hold_sel) begin
               res_ff[0] <= rd_value_ff[0];
               res_ff[1] <= rd_value_ff[1];
               res_ff[2] <= rd_value_ff[2];
            end
            t0_ff   <= rd_time_ff;
            a_ff[0] <= rd_value_ff[0];
            a_ff[1] <= rd_value_ff[1];
            a_ff[2] <= rd_value_ff[2];
         end
         kts_pkg::S_LD_B: begin
            rem_ff     <= t_ff - t0_ff;
            den_ff     <= rd_time_ff - t0_ff;
            k_ff       <= '0;
            div_cnt_ff <= DCW'(FRAC_BITS - 1);
            comp_ff    <= 2'd0;
            for (int c = 0; c < 3; c++) begin
               diff_ff[c] <= $signed({rd_value_ff[c][VW-1], rd_value_ff[c]}) -
                             $signed({a_ff[c][VW-1], a_ff[c]});
            end
         end
         kts_pkg::S_DIV: begin
            // one restoring quotient bit per cycle
            rem_ff     <= div_ge ? rem_sub[TW-1:0] : rem_sh[TW-1:0];
            k_ff       <= {k_ff[FRAC_BITS-2:0], div_ge};
            div_cnt_ff <= div_cnt_ff - DCW'(1);
         end
         kts_pkg::S_MUL: begin
            prod_ff <= prod_in;
         end
         kts_pkg::S_ACC: begin
            res_ff[comp_ff] <= sum_full[VW-1:0];
            comp_ff         <= comp_ff + 2'd1;
         end
         kts_pkg::S_DONE: begin
            if (rsp_load) begin
               rsp_out_ff[0] <= res_ff[0];
               rsp_out_ff[1] <= res_ff[1];
               rsp_out_ff[2] <= res_ff[2];
               rsp_status_ff <= res_status_ff;
            end
         end
         default: ;
      endcase
   end

   // response beat
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_out_ff[2], rsp_out_ff[1], rsp_out_ff[0]};
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   // an empty-table answer carries zero data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == kts_pkg::STATUS_EMPTY)) |-> (rsp_tdata == '0))
      else $error("empty table response with nonzero data");

   // divider remainder stays below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == kts_pkg::S_DIV) |-> (rem_ff < den_ff))
      else $error("divider remainder out of range");

   // the keyframe found lies inside the table in use
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == kts_pkg::S_LD_A) |-> (CW'(found_ff) < n_ff))
      else $error("found keyframe beyond key count");

   // a finished result waits while the output register is still full
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == kts_pkg::S_DONE) && rsp_valid_ff && !rsp_tready)
      |=> (state_ff == kts_pkg::S_DONE))
      else $error("result overwrote an untaken response");

   // a sample beat always starts work
   assert property (@(posedge clock) disable iff (reset)
      (req_beat && (req_tuser == kts_pkg::REQ_SAMPLE)) |=> !req_tready)
      else $error("sample beat did not start the sequencer");
`endif

endmodule
